@@ rtl/core/sppr_pkg.sv @@
// sppr_pkg: shared types, codes and sizes for the stereo pair ping-pong reader.
// No dependencies.

package sppr_pkg;

	localparam int WORDS_PER_HALF = 128;
	localparam int STORE_DEPTH    = 2 * WORDS_PER_HALF;
	localparam int POS_W          = $clog2(WORDS_PER_HALF);
	localparam int ADDR_W         = $clog2(STORE_DEPTH);
	localparam int WORD_W         = 25;
	localparam int SAMPLE_W       = 24;
	localparam int CNT_W          = 32;
	localparam int RIGHT_BIT      = 24;

	localparam logic [1:0] KIND_WORD  = 2'd0;
	localparam logic [1:0] KIND_PULL  = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;

	localparam logic [1:0] ST_PAIR   = 2'd0;
	localparam logic [1:0] ST_NODATA = 2'd1;
	localparam logic [1:0] ST_ORPHAN = 2'd2;
	localparam logic [1:0] ST_ACK    = 2'd3;

	typedef enum logic [1:0] {
		OP_WORD,
		OP_PULL,
		OP_CLEAR,
		OP_NOP
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [WORD_W-1:0] word;
	} item_t;

endpackage

@@ rtl/core/sppr_ram.sv @@
// sppr_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.

module sppr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

@@ rtl/core/sppr_front.sv @@
// sppr_front: accepts command words, classifies the kind, queues them (two deep).
// Depends on sppr_pkg.

module sppr_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [1:0]                     kind,
	input  logic [sppr_pkg::WORD_W-1:0]    captured_word,
	output logic                           busy,
	output logic                           item_valid,
	output sppr_pkg::item_t                item,
	input  logic                           item_pop
);

	sppr_pkg::item_t entry_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;
	logic            push;
	sppr_pkg::item_t in_item;

	assign busy       = (count_q == 2'd2);
	assign push       = start && !busy;
	assign item_valid = (count_q != 2'd0);
	assign item       = entry_q[rd_ptr_q];

	always_comb begin
		in_item.word = captured_word;
		case (kind)
			sppr_pkg::KIND_WORD:  in_item.op = sppr_pkg::OP_WORD;
			sppr_pkg::KIND_PULL:  in_item.op = sppr_pkg::OP_PULL;
			sppr_pkg::KIND_CLEAR: in_item.op = sppr_pkg::OP_CLEAR;
			default:              in_item.op = sppr_pkg::OP_NOP;
		endcase
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (item_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, item_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		item_pop |-> item_valid)
		else $error("pop from empty queue");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("queue count out of range");

	a_count_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !item_pop) |=> count_q == $past(count_q) + 2'd1)
		else $error("queue count did not follow push");

endmodule

@@ rtl/core/sppr_back.sv @@
// sppr_back: executes queued words: store writes, clears, pair assembly, overrun resync.
// Depends on sppr_pkg and sppr_ram.

module sppr_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	input  sppr_pkg::item_t                item,
	output logic                           item_pop,
	output logic                           done,
	output logic [1:0]                     status,
	output logic [sppr_pkg::SAMPLE_W-1:0]  left_sample,
	output logic [sppr_pkg::SAMPLE_W-1:0]  right_sample,
	output logic [sppr_pkg::CNT_W-1:0]     drop_total,
	output logic [sppr_pkg::CNT_W-1:0]     overrun_total,
	output logic [sppr_pkg::CNT_W-1:0]     last_overrun_gap
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_TAKE,
		S_EVAL
	} state_t;

	state_t                         state_q;
	logic [sppr_pkg::CNT_W-1:0]     hw_q;
	logic [sppr_pkg::CNT_W-1:0]     hr_q;
	logic [sppr_pkg::POS_W-1:0]     wp_q;
	logic [sppr_pkg::POS_W-1:0]     rp_q;
	logic                           lw_valid_q;
	logic [sppr_pkg::WORD_W-1:0]    lw_word_q;
	logic [sppr_pkg::CNT_W-1:0]     drop_q;
	logic [sppr_pkg::CNT_W-1:0]     ovr_q;
	logic [sppr_pkg::CNT_W-1:0]     gap_q;

	logic [sppr_pkg::CNT_W-1:0]     behind;
	logic                           ovr;
	logic [sppr_pkg::CNT_W-1:0]     hr_eff;
	logic [sppr_pkg::POS_W-1:0]     rp_eff;
	logic                           wr_en;
	logic [sppr_pkg::ADDR_W-1:0]    wr_addr;
	logic                           rd_en;
	logic [sppr_pkg::ADDR_W-1:0]    rd_addr;
	logic [sppr_pkg::WORD_W-1:0]    rd_data;

	localparam logic [sppr_pkg::POS_W-1:0] POS_LAST =
		sppr_pkg::POS_W'(sppr_pkg::WORDS_PER_HALF - 1);
	localparam logic [sppr_pkg::ADDR_W-1:0] HALF_BASE =
		sppr_pkg::ADDR_W'(sppr_pkg::WORDS_PER_HALF);

	assign item_pop = (state_q == S_IDLE) && item_valid;

	assign behind = hw_q - hr_q;
	assign ovr    = (behind > sppr_pkg::CNT_W'(1));
	assign hr_eff = ovr ? (hw_q - sppr_pkg::CNT_W'(1)) : hr_q;
	assign rp_eff = ovr ? '0 : rp_q;

	assign wr_en   = item_pop && (item.op == sppr_pkg::OP_WORD);
	assign wr_addr = sppr_pkg::ADDR_W'(wp_q) + (hw_q[0] ? HALF_BASE : '0);
	assign rd_en   = (state_q == S_TAKE) && (behind != '0);
	assign rd_addr = sppr_pkg::ADDR_W'(rp_eff) + (hr_eff[0] ? HALF_BASE : '0);

	assign drop_total       = drop_q;
	assign overrun_total    = ovr_q;
	assign last_overrun_gap = gap_q;

	sppr_ram #(
		.WIDTH (sppr_pkg::WORD_W),
		.DEPTH (sppr_pkg::STORE_DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (item.word),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk) begin
		if (state_q == S_EVAL && !rd_data[sppr_pkg::RIGHT_BIT]) begin
			lw_word_q <= rd_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			hw_q         <= '0;
			hr_q         <= '0;
			wp_q         <= '0;
			rp_q         <= '0;
			lw_valid_q   <= 1'b0;
			drop_q       <= '0;
			ovr_q        <= '0;
			gap_q        <= '0;
			done         <= 1'b0;
			status       <= sppr_pkg::ST_ACK;
			left_sample  <= '0;
			right_sample <= '0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (item_pop) begin
						left_sample  <= '0;
						right_sample <= '0;
						status       <= sppr_pkg::ST_ACK;
						case (item.op)
							sppr_pkg::OP_WORD: begin
								done <= 1'b1;
								if (wp_q == POS_LAST) begin
									wp_q <= '0;
									hw_q <= hw_q + sppr_pkg::CNT_W'(1);
								end else begin
									wp_q <= wp_q + sppr_pkg::POS_W'(1);
								end
							end
							sppr_pkg::OP_PULL: begin
								state_q <= S_TAKE;
							end
							sppr_pkg::OP_CLEAR: begin
								done       <= 1'b1;
								hw_q       <= '0;
								hr_q       <= '0;
								wp_q       <= '0;
								rp_q       <= '0;
								lw_valid_q <= 1'b0;
							end
							default: begin
								done <= 1'b1;
							end
						endcase
					end
				end
				S_TAKE: begin
					if (behind == '0) begin
						done    <= 1'b1;
						status  <= sppr_pkg::ST_NODATA;
						state_q <= S_IDLE;
					end else begin
						if (ovr) begin
							ovr_q      <= ovr_q + sppr_pkg::CNT_W'(1);
							gap_q      <= behind;
							lw_valid_q <= 1'b0;
						end
						if (rp_eff == POS_LAST) begin
							rp_q <= '0;
							hr_q <= hr_eff + sppr_pkg::CNT_W'(1);
						end else begin
							rp_q <= rp_eff + sppr_pkg::POS_W'(1);
							hr_q <= hr_eff;
						end
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					if (rd_data[sppr_pkg::RIGHT_BIT]) begin
						done    <= 1'b1;
						state_q <= S_IDLE;
						if (lw_valid_q) begin
							status       <= sppr_pkg::ST_PAIR;
							left_sample  <= lw_word_q[sppr_pkg::SAMPLE_W-1:0];
							right_sample <= rd_data[sppr_pkg::SAMPLE_W-1:0];
							lw_valid_q   <= 1'b0;
						end else begin
							status <= sppr_pkg::ST_ORPHAN;
							drop_q <= drop_q + sppr_pkg::CNT_W'(1);
						end
					end else begin
						// second left in a row restarts the pair
						if (lw_valid_q) begin
							drop_q <= drop_q + sppr_pkg::CNT_W'(1);
						end
						lw_valid_q <= 1'b1;
						state_q    <= S_TAKE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_eval_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EVAL) |-> $past(state_q) == S_TAKE)
		else $error("evaluate without a store read");

	a_pair_clears_left: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == sppr_pkg::ST_PAIR) |-> !lw_valid_q)
		else $error("left word still waiting after pair");

	a_overrun_step: assert property (@(posedge clk) disable iff (!arst_n)
		(ovr_q != $past(ovr_q)) |-> ovr_q == $past(ovr_q) + sppr_pkg::CNT_W'(1))
		else $error("overrun count jumped");

	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !item_pop)
		else $error("queue popped while an item is in progress");

endmodule

@@ rtl/core/stereo_pair_ping_pong_reader.sv @@
// stereo_pair_ping_pong_reader: top level, command queue front and execution back.
// Depends on sppr_pkg, sppr_front, sppr_back (which holds sppr_ram).
//
// channel   dir  handshake            words
// command   in   start && !busy       kind, captured_word
// result    out  done (one cycle)     status, left_sample, right_sample,
//                                     drop_total, overrun_total, last_overrun_gap
//
// Store word, clear and unused kind: queued, popped while idle, result registered.
// Pull: each store word read takes a RAM read step and an evaluate step, until a
// right word ends it with a result, or it ends with no data when none is left.
// Commands queue two deep; busy is high while both slots are full.
// arst_n clears positions, half counts and counters; store contents are not reset.
// Results cannot be held off; done marks each one for a single cycle.

module stereo_pair_ping_pong_reader (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [1:0]                     kind,
	input  logic [sppr_pkg::WORD_W-1:0]    captured_word,
	output logic                           done,
	output logic [1:0]                     status,
	output logic [sppr_pkg::SAMPLE_W-1:0]  left_sample,
	output logic [sppr_pkg::SAMPLE_W-1:0]  right_sample,
	output logic [sppr_pkg::CNT_W-1:0]     drop_total,
	output logic [sppr_pkg::CNT_W-1:0]     overrun_total,
	output logic [sppr_pkg::CNT_W-1:0]     last_overrun_gap
);

	logic            item_valid;
	logic            item_pop;
	sppr_pkg::item_t item;

	sppr_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.kind          (kind),
		.captured_word (captured_word),
		.busy          (busy),
		.item_valid    (item_valid),
		.item          (item),
		.item_pop      (item_pop)
	);

	sppr_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.item_valid       (item_valid),
		.item             (item),
		.item_pop         (item_pop),
		.done             (done),
		.status           (status),
		.left_sample      (left_sample),
		.right_sample     (right_sample),
		.drop_total       (drop_total),
		.overrun_total    (overrun_total),
		.last_overrun_gap (last_overrun_gap)
	);

endmodule
